### design/bta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types and constants of the buddy tree allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

    localparam int MAX_HEIGHT = 10;
    localparam int NODE_COUNT = (1 << (MAX_HEIGHT + 1)) - 1;
    localparam int NODE_AW    = $clog2(NODE_COUNT);
    localparam int HEIGHT_W   = 4;
    localparam int LVL_W      = 4;
    localparam int REQ_W      = 11;
    localparam int OFF_W      = 10;
    localparam int STATUS_W   = 2;
    localparam int NODE_W     = 2;

    typedef enum logic [NODE_W-1:0] {
        NODE_UNUSED = 2'd0,
        NODE_USED   = 2'd1,
        NODE_SPLIT  = 2'd2,
        NODE_FULL   = 2'd3
    } node_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NOSPACE = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_RD,
        ST_A_EVAL,
        ST_A_CL1,
        ST_A_CL2,
        ST_A_UP,
        ST_M_RD,
        ST_M_EVAL,
        ST_F_RD,
        ST_F_EVAL,
        ST_R_RD,
        ST_R_EVAL,
        ST_R_WR,
        ST_P_RD,
        ST_P_EVAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [0:0]       operation;
        logic [REQ_W-1:0] request_units;
        logic [OFF_W-1:0] free_offset;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    block_offset;
    } out_word_t;

endpackage

### design/bta_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bta_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2047
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/buddy_tree_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_tree_allocator_top
// Binary buddy allocator over a tree of node states held in one RAM.
// ----------------------------------------------------------------------------
// After reset and after every tree_height write the node RAM is swept to
// unused, one node a cycle, during which no word is taken. Each word then
// walks the tree through the single RAM read port: every node visit is a
// read state (address), then an evaluate state (decision). An allocate
// searches nodes, clears both children of each node it splits, climbs back
// levels during the search and marks ancestors full; a free walks levels
// down, merges buddies upward and turns full ancestors back to split, with
// entry in the idle state and hand-off in the done state. Input is taken
// only while the sequencer is idle.
module buddy_tree_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bta_pkg::in_word_t             in_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bta_pkg::out_word_t            out_word,
    input  logic                          cfg_we,
    input  logic [bta_pkg::HEIGHT_W-1:0]  cfg_wdata
);

    bta_pkg::state_t                  state_reg, state_next;
    logic [bta_pkg::HEIGHT_W-1:0]     height_reg, height_next;
    logic [bta_pkg::NODE_AW-1:0]      idx_reg, idx_next;
    logic [bta_pkg::LVL_W-1:0]        lvl_reg, lvl_next;
    logic [bta_pkg::LVL_W-1:0]        tl_reg, tl_next;
    logic [bta_pkg::REQ_W-1:0]        left_reg, left_next;
    logic [bta_pkg::OFF_W-1:0]        off_reg, off_next;
    logic [bta_pkg::NODE_AW-1:0]      clr_reg, clr_next;
    bta_pkg::status_t                 status_reg, status_next;
    logic [bta_pkg::OFF_W-1:0]        boff_reg, boff_next;
    logic                             out_valid_reg, out_valid_next;
    bta_pkg::out_word_t               out_word_reg, out_word_next;

    logic                             ram_we;
    logic [bta_pkg::NODE_AW-1:0]      ram_waddr;
    logic [bta_pkg::NODE_W-1:0]       ram_wdata;
    logic [bta_pkg::NODE_AW-1:0]      ram_raddr;
    logic [bta_pkg::NODE_W-1:0]       ram_rdata;
    bta_pkg::node_t                   node_rd;

    logic [bta_pkg::LVL_W-1:0]        h_eff;
    logic [bta_pkg::NODE_AW-1:0]      idx_up;
    logic [bta_pkg::NODE_AW-1:0]      idx_sib;
    logic [bta_pkg::NODE_AW-1:0]      idx_left;
    logic [bta_pkg::NODE_AW-1:0]      idx_right;
    logic [bta_pkg::LVL_W-1:0]        req_k;
    logic [bta_pkg::REQ_W-1:0]        req_m1;
    logic [bta_pkg::REQ_W-1:0]        half_len;
    logic [bta_pkg::NODE_AW-1:0]      node_rel;
    logic [bta_pkg::OFF_W-1:0]        node_off;

    bta_ram #(
        .WIDTH (bta_pkg::NODE_W),
        .DEPTH (bta_pkg::NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign node_rd   = bta_pkg::node_t'(ram_rdata);
    assign h_eff     = (height_reg > bta_pkg::LVL_W'(bta_pkg::MAX_HEIGHT))
                       ? bta_pkg::LVL_W'(bta_pkg::MAX_HEIGHT) : height_reg;
    assign idx_up    = (idx_reg - bta_pkg::NODE_AW'(1)) >> 1;
    assign idx_sib   = idx_reg[0] ? idx_reg + bta_pkg::NODE_AW'(1)
                                  : idx_reg - bta_pkg::NODE_AW'(1);
    assign idx_left  = bta_pkg::NODE_AW'({idx_reg, 1'b1});
    assign idx_right = idx_left + bta_pkg::NODE_AW'(1);
    assign req_m1    = in_word.request_units - bta_pkg::REQ_W'(1);
    assign half_len  = bta_pkg::REQ_W'(1) << (h_eff - lvl_reg - bta_pkg::LVL_W'(1));
    assign node_rel  = (idx_reg + bta_pkg::NODE_AW'(1)) - (bta_pkg::NODE_AW'(1) << lvl_reg);
    assign node_off  = bta_pkg::OFF_W'(node_rel << (h_eff - lvl_reg));

    // rounded-up size exponent
    always_comb
    begin
        req_k = '0;
        if (in_word.request_units > bta_pkg::REQ_W'(1))
        begin
            for (int b = 0; b < bta_pkg::REQ_W; b++)
            begin
                if (req_m1[b])
                begin
                    req_k = bta_pkg::LVL_W'(b + 1);
                end
            end
        end
    end

    // next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        height_next    = height_reg;
        idx_next       = idx_reg;
        lvl_next       = lvl_reg;
        tl_next        = tl_reg;
        left_next      = left_reg;
        off_next       = off_reg;
        clr_next       = clr_reg;
        status_next    = status_reg;
        boff_next      = boff_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bta_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + bta_pkg::NODE_AW'(1);
                if (clr_reg == bta_pkg::NODE_AW'(bta_pkg::NODE_COUNT - 1))
                begin
                    state_next = bta_pkg::ST_IDLE;
                end
            end
            bta_pkg::ST_IDLE:
            begin
                idx_next  = '0;
                lvl_next  = '0;
                left_next = '0;
                boff_next = '0;
                off_next  = in_word.free_offset;
                if (in_valid)
                begin
                    if (in_word.operation == bta_pkg::OP_FREE)
                    begin
                        if ((in_word.free_offset >> h_eff) != '0)
                        begin
                            status_next = bta_pkg::STATUS_INVALID;
                            state_next  = bta_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = bta_pkg::ST_F_RD;
                        end
                    end
                    else if (req_k > h_eff)
                    begin
                        status_next = bta_pkg::STATUS_NOSPACE;
                        state_next  = bta_pkg::ST_DONE;
                    end
                    else
                    begin
                        tl_next    = h_eff - req_k;
                        state_next = bta_pkg::ST_A_RD;
                    end
                end
            end
            bta_pkg::ST_A_RD:
            begin
                state_next = bta_pkg::ST_A_EVAL;
            end
            bta_pkg::ST_A_EVAL:
            begin
                if (lvl_reg == tl_reg && node_rd == bta_pkg::NODE_UNUSED)
                begin
                    boff_next   = node_off;
                    status_next = bta_pkg::STATUS_OK;
                    state_next  = bta_pkg::ST_M_RD;
                end
                else if (lvl_reg != tl_reg && node_rd == bta_pkg::NODE_UNUSED)
                begin
                    state_next = bta_pkg::ST_A_CL1;
                end
                else if (lvl_reg != tl_reg && node_rd == bta_pkg::NODE_SPLIT)
                begin
                    idx_next   = idx_left;
                    lvl_next   = lvl_reg + bta_pkg::LVL_W'(1);
                    state_next = bta_pkg::ST_A_RD;
                end
                else if (idx_reg[0])
                begin
                    idx_next   = idx_reg + bta_pkg::NODE_AW'(1);
                    state_next = bta_pkg::ST_A_RD;
                end
                else
                begin
                    state_next = bta_pkg::ST_A_UP;
                end
            end
            bta_pkg::ST_A_CL1:
            begin
                state_next = bta_pkg::ST_A_CL2;
            end
            bta_pkg::ST_A_CL2:
            begin
                idx_next   = idx_left;
                lvl_next   = lvl_reg + bta_pkg::LVL_W'(1);
                state_next = bta_pkg::ST_A_RD;
            end
            bta_pkg::ST_A_UP:
            begin
                if (idx_reg == '0)
                begin
                    status_next = bta_pkg::STATUS_NOSPACE;
                    state_next  = bta_pkg::ST_DONE;
                end
                else
                begin
                    lvl_next = lvl_reg - bta_pkg::LVL_W'(1);
                    if (idx_up[0])
                    begin
                        idx_next   = idx_up + bta_pkg::NODE_AW'(1);
                        state_next = bta_pkg::ST_A_RD;
                    end
                    else
                    begin
                        idx_next = idx_up;
                    end
                end
            end
            bta_pkg::ST_M_RD:
            begin
                if (idx_reg == '0)
                begin
                    state_next = bta_pkg::ST_DONE;
                end
                else
                begin
                    state_next = bta_pkg::ST_M_EVAL;
                end
            end
            bta_pkg::ST_M_EVAL:
            begin
                if (node_rd == bta_pkg::NODE_USED || node_rd == bta_pkg::NODE_FULL)
                begin
                    idx_next   = idx_up;
                    state_next = bta_pkg::ST_M_RD;
                end
                else
                begin
                    state_next = bta_pkg::ST_DONE;
                end
            end
            bta_pkg::ST_F_RD:
            begin
                state_next = bta_pkg::ST_F_EVAL;
            end
            bta_pkg::ST_F_EVAL:
            begin
                if (node_rd == bta_pkg::NODE_USED)
                begin
                    if (bta_pkg::REQ_W'(off_reg) != left_reg)
                    begin
                        status_next = bta_pkg::STATUS_INVALID;
                        state_next  = bta_pkg::ST_DONE;
                    end
                    else
                    begin
                        status_next = bta_pkg::STATUS_OK;
                        state_next  = bta_pkg::ST_R_RD;
                    end
                end
                else if (node_rd == bta_pkg::NODE_UNUSED || lvl_reg >= h_eff)
                begin
                    status_next = bta_pkg::STATUS_INVALID;
                    state_next  = bta_pkg::ST_DONE;
                end
                else
                begin
                    lvl_next   = lvl_reg + bta_pkg::LVL_W'(1);
                    state_next = bta_pkg::ST_F_RD;
                    if (bta_pkg::REQ_W'(off_reg) < left_reg + half_len)
                    begin
                        idx_next = idx_left;
                    end
                    else
                    begin
                        left_next = left_reg + half_len;
                        idx_next  = idx_right;
                    end
                end
            end
            bta_pkg::ST_R_RD:
            begin
                if (idx_reg == '0)
                begin
                    state_next = bta_pkg::ST_R_WR;
                end
                else
                begin
                    state_next = bta_pkg::ST_R_EVAL;
                end
            end
            bta_pkg::ST_R_EVAL:
            begin
                if (node_rd != bta_pkg::NODE_UNUSED)
                begin
                    state_next = bta_pkg::ST_R_WR;
                end
                else
                begin
                    idx_next   = idx_up;
                    state_next = bta_pkg::ST_R_RD;
                end
            end
            bta_pkg::ST_R_WR:
            begin
                idx_next   = (idx_reg == '0) ? '0 : idx_up;
                state_next = bta_pkg::ST_P_RD;
            end
            bta_pkg::ST_P_RD:
            begin
                state_next = bta_pkg::ST_P_EVAL;
            end
            bta_pkg::ST_P_EVAL:
            begin
                if (node_rd == bta_pkg::NODE_FULL && idx_reg != '0)
                begin
                    idx_next   = idx_up;
                    state_next = bta_pkg::ST_P_RD;
                end
                else
                begin
                    state_next = bta_pkg::ST_DONE;
                end
            end
            bta_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next             = 1'b1;
                    out_word_next.status       = status_reg;
                    out_word_next.block_offset =
                        (status_reg == bta_pkg::STATUS_OK) ? boff_reg : '0;
                    state_next                 = bta_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bta_pkg::ST_CLEAR;
            end
        endcase

        if (cfg_we)
        begin
            height_next = cfg_wdata;
            clr_next    = '0;
            state_next  = bta_pkg::ST_CLEAR;
        end
    end

    // node ram control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = bta_pkg::NODE_UNUSED;
        ram_raddr = idx_reg;
        in_ready  = 1'b0;

        unique case (state_reg)
            bta_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
            end
            bta_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            bta_pkg::ST_A_EVAL:
            begin
                if (node_rd == bta_pkg::NODE_UNUSED)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = (lvl_reg == tl_reg) ? bta_pkg::NODE_USED
                                                    : bta_pkg::NODE_SPLIT;
                end
            end
            bta_pkg::ST_A_CL1:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_left;
            end
            bta_pkg::ST_A_CL2:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_right;
            end
            bta_pkg::ST_M_RD, bta_pkg::ST_R_RD:
            begin
                ram_raddr = idx_sib;
            end
            bta_pkg::ST_M_EVAL:
            begin
                if (node_rd == bta_pkg::NODE_USED || node_rd == bta_pkg::NODE_FULL)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_up;
                    ram_wdata = bta_pkg::NODE_FULL;
                end
            end
            bta_pkg::ST_R_WR:
            begin
                ram_we = 1'b1;
            end
            bta_pkg::ST_P_EVAL:
            begin
                if (node_rd == bta_pkg::NODE_FULL)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = bta_pkg::NODE_SPLIT;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bta_pkg::ST_CLEAR;
            height_reg    <= bta_pkg::HEIGHT_W'(bta_pkg::MAX_HEIGHT);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            height_reg    <= height_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        lvl_reg      <= lvl_next;
        tl_reg       <= tl_next;
        left_reg     <= left_next;
        off_reg      <= off_next;
        status_reg   <= status_next;
        boff_reg     <= boff_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

### tb/sv/bta_alloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_alloc_checker
// Watches the word channels and the height register of the buddy allocator,
// keeps its own copy of the node tree, predicts the status and offset of
// every accepted word and compares each delivered word with the oldest
// prediction.
// ----------------------------------------------------------------------------
module bta_alloc_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  bta_pkg::in_word_t            in_word,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  bta_pkg::out_word_t           out_word,
    input  logic                         cfg_we,
    input  logic [bta_pkg::HEIGHT_W-1:0] cfg_wdata,
    output int                           fail_count,
    output int                           pending,
    output int                           checked_count
);

    bta_pkg::node_t               tree_nodes [bta_pkg::NODE_COUNT];
    logic [bta_pkg::HEIGHT_W-1:0] cur_height;
    bta_pkg::out_word_t           expected_words [$];

    function automatic int unsigned height_in_use();
        return (cur_height > bta_pkg::MAX_HEIGHT) ? bta_pkg::MAX_HEIGHT : cur_height;
    endfunction

    function automatic bta_pkg::node_t node_rd(input int unsigned i);
        if (i < bta_pkg::NODE_COUNT)
            return tree_nodes[i];
        return bta_pkg::NODE_UNUSED;
    endfunction

    function automatic void node_wr(input int unsigned i, input bta_pkg::node_t v);
        if (i < bta_pkg::NODE_COUNT)
            tree_nodes[i] = v;
    endfunction

    function automatic int unsigned parent_of(input int unsigned i);
        return (i > 0) ? (i + 1) / 2 - 1 : 0;
    endfunction

    function automatic int unsigned buddy_of(input int unsigned i);
        return (i > 0) ? i - 1 + (i & 1) * 2 : 0;
    endfunction

    function automatic void clear_tree();
        foreach (tree_nodes[i])
            tree_nodes[i] = bta_pkg::NODE_UNUSED;
    endfunction

    function automatic void mark_ancestors_full(input int unsigned start);
        int unsigned    i;
        int unsigned    s;
        bta_pkg::node_t v;
        i = start;
        forever
        begin
            s = buddy_of(i);
            v = node_rd(s);
            if (s != 0 && (v == bta_pkg::NODE_USED || v == bta_pkg::NODE_FULL))
            begin
                i = parent_of(i);
                node_wr(i, bta_pkg::NODE_FULL);
            end
            else
                return;
        end
    endfunction

    function automatic bit alloc_block(input int unsigned req, output int unsigned off);
        int unsigned    h;
        int unsigned    len;
        int unsigned    size;
        int unsigned    idx;
        int unsigned    lvl;
        bta_pkg::node_t v;
        h    = height_in_use();
        len  = 1 << h;
        size = 1;
        idx  = 0;
        lvl  = 0;
        off  = 0;
        while (size < req)
            size = size << 1;
        if (size > len)
            return 0;
        forever
        begin
            v = node_rd(idx);
            if (size == len)
            begin
                if (v == bta_pkg::NODE_UNUSED)
                begin
                    node_wr(idx, bta_pkg::NODE_USED);
                    mark_ancestors_full(idx);
                    off = ((idx + 1) - (1 << lvl)) << (h - lvl);
                    return 1;
                end
            end
            else if (v == bta_pkg::NODE_UNUSED || v == bta_pkg::NODE_SPLIT)
            begin
                if (v == bta_pkg::NODE_UNUSED)
                begin
                    node_wr(idx, bta_pkg::NODE_SPLIT);
                    node_wr(2 * idx + 1, bta_pkg::NODE_UNUSED);
                    node_wr(2 * idx + 2, bta_pkg::NODE_UNUSED);
                end
                idx = 2 * idx + 1;
                len = len >> 1;
                lvl++;
                continue;
            end
            if (idx & 1)
            begin
                idx++;
                continue;
            end
            forever
            begin
                if (idx == 0)
                    return 0;
                lvl--;
                len = len << 1;
                idx = parent_of(idx);
                if (idx & 1)
                begin
                    idx++;
                    break;
                end
            end
        end
    endfunction

    function automatic void release_block(input int unsigned start);
        int unsigned i;
        int unsigned s;
        i = start;
        forever
        begin
            s = buddy_of(i);
            if (s == 0 || node_rd(s) != bta_pkg::NODE_UNUSED)
            begin
                node_wr(i, bta_pkg::NODE_UNUSED);
                i = parent_of(i);
                while (node_rd(i) == bta_pkg::NODE_FULL)
                begin
                    node_wr(i, bta_pkg::NODE_SPLIT);
                    if (i == 0)
                        break;
                    i = parent_of(i);
                end
                return;
            end
            i = parent_of(i);
        end
    endfunction

    function automatic bit free_block(input int unsigned off);
        int unsigned    h;
        int unsigned    len;
        int unsigned    left;
        int unsigned    idx;
        int unsigned    lvl;
        bta_pkg::node_t v;
        h    = height_in_use();
        len  = 1 << h;
        left = 0;
        idx  = 0;
        lvl  = 0;
        if (off >= len)
            return 0;
        forever
        begin
            v = node_rd(idx);
            if (v == bta_pkg::NODE_USED)
            begin
                if (off != left)
                    return 0;
                release_block(idx);
                return 1;
            end
            if (v == bta_pkg::NODE_UNUSED || lvl >= h)
                return 0;
            len = len >> 1;
            lvl++;
            if (off < left + len)
                idx = 2 * idx + 1;
            else
            begin
                left = left + len;
                idx  = 2 * idx + 2;
            end
        end
    endfunction

    function automatic bta_pkg::out_word_t predict_word(input bta_pkg::in_word_t w);
        bta_pkg::out_word_t r;
        int unsigned        off;
        r = '0;
        if (w.operation == bta_pkg::OP_ALLOC)
        begin
            if (alloc_block(w.request_units, off))
            begin
                r.status       = bta_pkg::STATUS_OK;
                r.block_offset = off[bta_pkg::OFF_W-1:0];
            end
            else
                r.status = bta_pkg::STATUS_NOSPACE;
        end
        else
            r.status = free_block(w.free_offset) ? bta_pkg::STATUS_OK
                                                 : bta_pkg::STATUS_INVALID;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bta_pkg::out_word_t exp_w;
        if (!rst_n)
        begin
            clear_tree();
            cur_height = bta_pkg::HEIGHT_W'(bta_pkg::MAX_HEIGHT);
            expected_words.delete();
            fail_count    <= 0;
            checked_count <= 0;
            pending       <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                cur_height = cfg_wdata;
                clear_tree();
            end
            if (in_valid && in_ready)
                expected_words = {expected_words, predict_word(in_word)};
            if (out_valid && out_ready)
            begin
                checked_count <= checked_count + 1;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: expected no word, actual %h", $time, out_word);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (exp_w.status !== out_word.status
                        || exp_w.block_offset !== out_word.block_offset)
                    begin
                        $display("%0t: expected status %0d offset %0d, actual %0d %0d",
                                 $time, exp_w.status, exp_w.block_offset,
                                 out_word.status, out_word.block_offset);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_words.size();
        end
    end

endmodule

### tb/sv/buddy_tree_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_tree_allocator_top_tb
// Drives allocate and free words into the buddy allocator across several
// tree heights and idling patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module buddy_tree_allocator_top_tb;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int PHASE_ITEMS  = 200;
    localparam int PHASE_COUNT  = 7;
    localparam int IN_W         = $bits(bta_pkg::in_word_t);

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    bta_pkg::in_word_t            in_word;
    logic                         out_valid;
    logic                         out_ready;
    bta_pkg::out_word_t           out_word;
    logic                         cfg_we;
    logic [bta_pkg::HEIGHT_W-1:0] cfg_wdata;

    int           fail_count;
    int           pending;
    int           checked_count;
    int           cycle_count = 0;
    int           idle_mode;
    int unsigned  cur_h;
    int unsigned  live_offsets [$];
    bta_pkg::op_t ops_in_flight [$];
    int unsigned  heights [PHASE_COUNT] = '{10, 0, 15, 3, 1, 10, 6};

    buddy_tree_allocator_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    bta_alloc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_word       (in_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_word      (out_word),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (idle_mode == 2)
            out_ready <= ($urandom_range(0, 99) >= 46);
        else if (idle_mode == 3)
            out_ready <= ($urandom_range(0, 99) >= 37);
        else
            out_ready <= 1'b1;
    end

    // remember granted offsets so that most frees are well formed
    always @(posedge clk)
    begin
        bta_pkg::op_t op;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                ops_in_flight = {ops_in_flight, bta_pkg::op_t'(in_word.operation)};
            if (out_valid && out_ready && ops_in_flight.size() > 0)
            begin
                op = ops_in_flight.pop_front();
                if (op == bta_pkg::OP_ALLOC && out_word.status == bta_pkg::STATUS_OK)
                    live_offsets = {live_offsets, int'(out_word.block_offset)};
            end
        end
    end

    task automatic send_word(input bta_pkg::in_word_t w);
        int idle_pct;
        idle_pct = (idle_mode == 1) ? 46 : (idle_mode == 3) ? 37 : 0;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            in_word  <= bta_pkg::in_word_t'(IN_W'($urandom));
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        forever
        begin
            @(negedge clk);
            if (in_ready)
            begin
                @(posedge clk);
                break;
            end
        end
    endtask

    task automatic alloc_req(input int unsigned units);
        bta_pkg::in_word_t w;
        w               = bta_pkg::in_word_t'(IN_W'($urandom));
        w.operation     = bta_pkg::OP_ALLOC;
        w.request_units = units[bta_pkg::REQ_W-1:0];
        send_word(w);
    endtask

    task automatic free_req(input int unsigned off);
        bta_pkg::in_word_t w;
        w             = bta_pkg::in_word_t'(IN_W'($urandom));
        w.operation   = bta_pkg::OP_FREE;
        w.free_offset = off[bta_pkg::OFF_W-1:0];
        send_word(w);
    endtask

    task automatic random_word();
        int unsigned pick;
        int unsigned k;
        int unsigned region;
        region = 1 << cur_h;
        pick   = $urandom_range(0, 99);
        if (live_offsets.size() == 0 ? pick < 85
                                     : (int'(pick) < 50 - int'(live_offsets.size())))
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                alloc_req($urandom_range(0, 8));
            else if (pick < 88)
                alloc_req($urandom_range(0, 64));
            else if (pick < 97)
                alloc_req($urandom_range(0, region));
            else
                alloc_req($urandom_range(0, 1024));
        end
        else if (live_offsets.size() > 0 && $urandom_range(0, 99) < 80)
        begin
            k = $urandom_range(0, live_offsets.size() - 1);
            free_req(live_offsets[k]);
            live_offsets.delete(k);
        end
        else if (live_offsets.size() > 0 && $urandom_range(0, 1))
            free_req(live_offsets[$urandom_range(0, live_offsets.size() - 1)]
                     + $urandom_range(1, 3));
        else
            free_req($urandom_range(0, 1023));
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0 || ops_in_flight.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        idle_mode   = 0;
        cur_h       = 10;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: sizes, rounding, misaligned and unused frees
        alloc_req(0);
        alloc_req(1);
        alloc_req(2);
        alloc_req(3);
        alloc_req(1024);
        free_req(5);
        free_req(3);
        free_req(512);
        free_req(1023);
        alloc_req(512);
        alloc_req(512);
        free_req(512);
        free_req(512);
        free_req(0);
        free_req(1);
        free_req(2);
        free_req(4);
        alloc_req(1024);
        free_req(0);
        alloc_req(1025);
        alloc_req(2047);
        in_valid <= 1'b0;
        wait_drained();
        live_offsets.delete();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            idle_mode = p % 4;
            if (p != 0)
            begin
                cfg_we    <= 1'b1;
                cfg_wdata <= heights[p][bta_pkg::HEIGHT_W-1:0];
                @(posedge clk);
                cfg_we    <= 1'b0;
                live_offsets.delete();
                cur_h = (heights[p] > bta_pkg::MAX_HEIGHT) ? bta_pkg::MAX_HEIGHT
                                                           : heights[p];
                // whole region, one unit, then frees at 0 and at 1023 (past the end below height 10)
                alloc_req(1 << cur_h);
                alloc_req(1);
                free_req(0);
                free_req(1023);
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_word();
            in_valid <= 1'b0;
            wait_drained();
        end

        repeat (50) @(posedge clk);
        $display("covered %0d words over %0d tree heights and four idling patterns",
                 checked_count, PHASE_COUNT);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
